// ===== src/robin_hood_hash_insert_core_macros.svh =====
`ifndef ROBIN_HOOD_HASH_INSERT_CORE_MACROS_SVH
`define ROBIN_HOOD_HASH_INSERT_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rh check failed");
// Next-cycle implication checked outside reset.
`define RH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rh check failed");
`endif

// ===== src/rhh_pkg.sv =====
package rhh_pkg;

  localparam logic [63:0] HASH_INIT = 64'd5381;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [0:0] REG_CAPACITY  = 1'd0;
  localparam logic [0:0] REG_KEY_BYTES = 1'd1;

  typedef struct packed {
    logic [63:0] key_word;
    logic        write_value;
    logic [31:0] new_value;
  } rhh_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_index;
    logic [31:0] old_value;
    logic [6:0]  entry_count;
  } rhh_out_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_HASH,
    CMD_MOD,
    CMD_READ,
    CMD_PROBE,
    CMD_PLACE
  } rhh_cmd_e;

  typedef struct packed {
    rhh_cmd_e cmd;
  } rhh_ctl_t;

  typedef struct packed {
    logic hash_done;
    logic mod_done;
    logic hit;
    logic stop;
    logic place_done;
  } rhh_sts_t;

endpackage

// ===== src/rhh_ctrl.sv =====
module rhh_ctrl
  import rhh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rhh_sts_t sts,
  output rhh_ctl_t ctl,
  output logic     res_load
);

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_MOD, S_READ, S_PROBE, S_PLACE, S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !res_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:  if (in_valid) state <= S_HASH;
        S_HASH:  if (sts.hash_done) state <= S_MOD;
        S_MOD:   if (sts.mod_done) state <= S_READ;
        S_READ: begin
          if (sts.hit) state <= S_DONE;
          else if (sts.stop) state <= S_PLACE;
          else state <= S_PROBE;
        end
        S_PROBE: state <= S_READ;
        S_PLACE: if (sts.place_done) state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign res_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    case (state)
      S_IDLE:  ctl.cmd = (in_valid) ? CMD_LOAD : CMD_NONE;
      S_HASH:  ctl.cmd = CMD_HASH;
      S_MOD:   ctl.cmd = CMD_MOD;
      S_READ:  ctl.cmd = CMD_READ;
      S_PROBE: ctl.cmd = CMD_PROBE;
      S_PLACE: ctl.cmd = CMD_PLACE;
      default: ctl.cmd = CMD_NONE;
    endcase
  end

endmodule

// ===== src/rhh_dpath.sv =====
module rhh_dpath
  import rhh_pkg::*;
#(
  parameter int SLOTS         = 64,
  parameter int KEY_BYTES_MAX = 8,
  parameter int VALUE_BITS    = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  rhh_ctl_t        ctl,
  output rhh_sts_t        sts,
  input  rhh_in_t         in_data,
  input  logic            res_load,
  output rhh_out_t        out_data,
  input  logic            cfg_valid,
  input  logic [0:0]      cfg_index,
  input  logic [6:0]      cfg_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = 8 * KEY_BYTES_MAX;
  localparam int BW = $clog2(KEY_BYTES_MAX + 1);

  logic [6:0] capacity;
  logic [3:0] key_bytes;

  logic [SLOTS-1:0]      slot_used;
  logic [CW-1:0]         dist_mem [SLOTS];
  logic [KW-1:0]         key_mem  [SLOTS];
  logic [VALUE_BITS-1:0] val_mem  [SLOTS];
  logic [CW-1:0]         occupied_count;

  logic [CW-1:0]         cap;
  logic [BW-1:0]         kb;
  logic [KW-1:0]         kmask;
  logic [KW-1:0]         key;
  logic                  wr;
  logic [VALUE_BITS-1:0] nv;
  logic [63:0]           hash;
  logic [BW-1:0]         byte_cnt;
  logic [6:0]            mod_cnt;
  logic [AW-1:0]         pos;
  logic [AW-1:0]         home;
  logic [CW-1:0]         d;
  logic                  cv;
  logic [CW-1:0]         cd;
  logic [KW-1:0]         ck;
  logic [VALUE_BITS-1:0] cval;
  logic                  first;
  logic                  rd_used;
  logic [CW-1:0]         rd_dist;
  logic [KW-1:0]         rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  hit_r;
  logic                  full_r;
  logic [VALUE_BITS-1:0] old_r;
  logic [AW-1:0]         pos_next;
  logic [7:0]            cur_byte;
  logic [63:0]           hash_next;
  logic [63:0]           cap_sh;
  logic                  swap;

  always_comb begin
    cap = (capacity == 7'd0) ? CW'(1) :
          ({25'd0, capacity} > SLOTS) ? CW'(SLOTS) : CW'(capacity);
    kb = ({28'd0, key_bytes} > KEY_BYTES_MAX) ? BW'(KEY_BYTES_MAX) : BW'(key_bytes);
    for (int i = 0; i < KEY_BYTES_MAX; i++) begin
      kmask[8*i +: 8] = (i < int'(kb)) ? 8'hFF : 8'h00;
    end
    pos_next = ({1'b0, pos} + 1'b1 >= {1'b0, cap[AW-1:0]} && (32'(pos) + 1 >= 32'(cap)))
               ? '0 : pos + 1'b1;
    cur_byte  = key[8*byte_cnt[BW-1:0] +: 8];
    hash_next = (hash << 5) + hash + {{56{cur_byte[7]}}, cur_byte};
    cap_sh    = 64'(cap) << mod_cnt[5:0];
    swap      = !rd_used || (rd_dist < cd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= 7'd64;
      key_bytes      <= 4'd1;
      slot_used      <= '0;
      occupied_count <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_CAPACITY) capacity <= cfg_data;
        else key_bytes <= cfg_data[3:0];
      end
      if (ctl.cmd == CMD_PLACE && !first && swap) begin
        slot_used[pos] <= cv;
      end
      if (ctl.cmd == CMD_PLACE && !first && !full_r && !sts.place_done && !rd_used) begin
        occupied_count <= occupied_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sts.hash_done  <= 1'b0;
    sts.mod_done   <= 1'b0;
    sts.place_done <= 1'b0;
    sts.hit        <= 1'b0;
    sts.stop       <= 1'b0;
    rd_used <= slot_used[pos];
    rd_dist <= dist_mem[pos];
    rd_key  <= key_mem[pos];
    rd_val  <= val_mem[pos];
    case (ctl.cmd)
      CMD_LOAD: begin
        key      <= in_data.key_word[KW-1:0] & kmask;
        wr       <= in_data.write_value;
        nv       <= VALUE_BITS'($signed(in_data.new_value));
        hash     <= HASH_INIT;
        byte_cnt <= '0;
        mod_cnt  <= 7'd0;
        d        <= '0;
        hit_r    <= 1'b0;
        full_r   <= 1'b0;
        first    <= 1'b1;
        sts.hash_done <= (kb == '0);
      end
      CMD_HASH: begin
        if (!sts.hash_done) begin
          hash     <= hash_next;
          byte_cnt <= byte_cnt + 1'b1;
          sts.hash_done <= (byte_cnt + 1'b1 == kb);
        end
        mod_cnt <= 7'd63;
      end
      CMD_MOD: begin
        if (!sts.mod_done) begin
          if (hash >= cap_sh && (cap_sh >> mod_cnt[5:0]) == 64'(cap)) hash <= hash - cap_sh;
          mod_cnt <= mod_cnt - 1'b1;
          sts.mod_done <= (mod_cnt == 7'd0);
        end else begin
          pos <= AW'(hash);
        end
      end
      CMD_PROBE: begin
        if (rd_used && rd_dist >= d) begin
          if ((rd_key & kmask) == key) begin
            hit_r <= 1'b1;
            old_r <= rd_val;
            sts.hit <= 1'b1;
            if (wr) val_mem[pos] <= nv;
          end else begin
            d   <= d + 1'b1;
            pos <= pos_next;
          end
        end else begin
          sts.stop <= 1'b1;
          home <= pos;
          cv   <= 1'b1;
          cd   <= d;
          ck   <= key;
          cval <= '0;
          old_r <= '0;
          full_r <= (occupied_count >= cap);
        end
      end
      CMD_PLACE: begin
        if (full_r) begin
          sts.place_done <= 1'b1;
        end else if (first) begin
          first <= 1'b0;
        end else if (!sts.place_done) begin
          if (swap) begin
            dist_mem[pos] <= cd;
            key_mem[pos]  <= ck;
            val_mem[pos]  <= (pos == home && wr) ? nv : cval;
            cd   <= rd_dist + 1'b1;
            ck   <= rd_key;
            cval <= rd_val;
            cv   <= rd_used;
            if (!rd_used) sts.place_done <= 1'b1;
          end else begin
            cd <= cd + 1'b1;
          end
          pos <= pos_next;
          first <= 1'b1;
        end
      end
      default: ;
    endcase
    if (ctl.cmd == CMD_PLACE && first && !full_r && !sts.place_done && cv == 1'b0) begin
      sts.place_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data.status      <= hit_r ? ST_FOUND : full_r ? ST_FULL : ST_INSERTED;
      out_data.slot_index  <= (full_r && !hit_r) ? 6'd0 : 6'(hit_r ? pos : home);
      out_data.old_value   <= hit_r ? 32'(old_r) : 32'd0;
      out_data.entry_count <= 7'(occupied_count);
    end
  end

endmodule

// ===== src/robin_hood_hash_insert_core.sv =====
// A request runs through these steps in order: the key bytes are hashed one at a time, the
// hash is reduced modulo the capacity, slots are probed from the home slot until a hit or a
// stop, and on a stop an insert walks the table unless it is full.
// One request at a time: the next input beat can be taken in the same cycle the result beat
// is presented; a result is held back while an earlier result still waits for out_ready.
// Synchronous active-high reset empties all slots, sets capacity 64, key_bytes 1.
module robin_hood_hash_insert_core
  import rhh_pkg::*;
#(
  parameter int SLOTS         = 64,
  parameter int KEY_BYTES_MAX = 8,
  parameter int VALUE_BITS    = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  rhh_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output rhh_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data
);

  rhh_ctl_t ctl;
  rhh_sts_t sts;
  logic     res_load;

  assign cfg_ready = 1'b1;

  rhh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .ctl(ctl),
    .res_load(res_load)
  );

  rhh_dpath #(
    .SLOTS(SLOTS), .KEY_BYTES_MAX(KEY_BYTES_MAX), .VALUE_BITS(VALUE_BITS)
  ) u_dpath (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts), .in_data(in_data),
    .res_load(res_load), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

endmodule

// ===== src/rhh_checker.sv =====
`include "robin_hood_hash_insert_core_macros.svh"
module rhh_checker
  import rhh_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input rhh_out_t out_data
);
  `RH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `RH_ASSERT_IMP(a_status_ok, out_valid, out_data.status != 2'd3)
  `RH_ASSERT_IMP(a_full_slot, out_valid && out_data.status == ST_FULL,
    out_data.slot_index == 6'd0 && out_data.old_value == 32'd0)
  `RH_ASSERT_NEXT(a_one_inflight, in_valid && in_ready, !in_ready)
endmodule

bind robin_hood_hash_insert_core rhh_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
